// ===== hdl/rtqt_pkg.sv =====
// Shared constants, codes and helpers for the read tail quality trim block.
`default_nettype none
package rtqt_pkg;

	localparam int MAX_READ_LEN = 1024;
	localparam int LEN_W = 11;
	localparam int CNT_W = 32;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// position saturates at the read length bound, never above 2047
	localparam logic [LEN_W-1:0] LEN_CAP =
		(MAX_READ_LEN < 2047) ? LEN_W'(MAX_READ_LEN) : LEN_W'(2047);

	localparam logic [1:0] REG_OFFSET = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;
	localparam logic [1:0] REG_MINLEN = 2'd2;
	localparam logic [1:0] REG_PAIRED = 2'd3;

	localparam logic [7:0] OFFSET_RST = 8'd33;
	localparam logic [6:0] THRESH_RST = 7'd2;
	localparam logic [LEN_W-1:0] MINLEN_RST = LEN_W'(60);

	localparam logic [1:0] FATE_PAIR  = 2'd0;
	localparam logic [1:0] FATE_ALONE = 2'd1;
	localparam logic [1:0] FATE_DROP  = 2'd2;
	localparam logic [1:0] FATE_NONE  = 2'd3;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
		input logic [1:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, cnt} + {{(CNT_W-1){1'b0}}, n};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/read_tail_quality_trim_core.sv =====
// A result is formed from the input register into the result register.
// Throughput: one quality byte per cycle while in_stall is low; the input
// and result registers are split so an item is taken while a result waits.
// Bytes that end no read and first mates in paired mode give no result.
// Reset (arst_n low) clears counters, position state and valids, and loads
// the register defaults (offset 33, threshold 2, min length 60, single mode).
`default_nettype none
module read_tail_quality_trim_core (
	input  wire                           clk,
	input  wire                           arst_n,
	// APB configuration
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [rtqt_pkg::ADDR_W-1:0]   paddr,
	input  wire  [rtqt_pkg::DATA_W-1:0]   pwdata,
	output logic [rtqt_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// input items
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [7:0]                    quality_byte,
	input  wire                           mate,
	input  wire                           read_end,
	// result items
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [rtqt_pkg::LEN_W-1:0]    length_first,
	output logic [rtqt_pkg::LEN_W-1:0]    length_second,
	output logic [1:0]                    fate_first,
	output logic [1:0]                    fate_second,
	output logic [rtqt_pkg::CNT_W-1:0]    kept_total,
	output logic [rtqt_pkg::CNT_W-1:0]    discarded_total,
	output logic [rtqt_pkg::CNT_W-1:0]    orphaned_total
);

	logic [7:0]                  offset_q;
	logic [6:0]                  thresh_q;
	logic [rtqt_pkg::LEN_W-1:0]  minlen_q;
	logic                        paired_q;

	logic                        valid_s1;
	logic [7:0]                  qual_s1;
	logic                        mate_s1;
	logic                        end_s1;

	logic [rtqt_pkg::LEN_W-1:0]  pos_q;
	logic [rtqt_pkg::LEN_W-1:0]  good_len_q;
	logic [rtqt_pkg::LEN_W-1:0]  held_len_q;
	logic [rtqt_pkg::CNT_W-1:0]  kept_q;
	logic [rtqt_pkg::CNT_W-1:0]  disc_q;
	logic [rtqt_pkg::CNT_W-1:0]  orph_q;

	logic                        wr_en;
	logic [1:0]                  reg_sel;
	logic [rtqt_pkg::LEN_W-1:0]  pos_inc;
	logic [8:0]                  limit;
	logic                        good;
	logic [rtqt_pkg::LEN_W-1:0]  good_len_nx;
	logic                        first_end;
	logic                        has_res;
	logic                        advance;
	logic [rtqt_pkg::LEN_W-1:0]  len1;
	logic [rtqt_pkg::LEN_W-1:0]  len2;
	logic                        pass1;
	logic                        pass2;
	logic [1:0]                  fate1;
	logic [1:0]                  fate2;
	logic [1:0]                  kept_add;
	logic [1:0]                  disc_add;
	logic [1:0]                  orph_add;
	logic [rtqt_pkg::CNT_W-1:0]  kept_nx;
	logic [rtqt_pkg::CNT_W-1:0]  disc_nx;
	logic [rtqt_pkg::CNT_W-1:0]  orph_nx;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= rtqt_pkg::OFFSET_RST;
			thresh_q <= rtqt_pkg::THRESH_RST;
			minlen_q <= rtqt_pkg::MINLEN_RST;
			paired_q <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				rtqt_pkg::REG_OFFSET: offset_q <= pwdata[7:0];
				rtqt_pkg::REG_THRESH: thresh_q <= pwdata[6:0];
				rtqt_pkg::REG_MINLEN: minlen_q <= pwdata[rtqt_pkg::LEN_W-1:0];
				rtqt_pkg::REG_PAIRED: paired_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			rtqt_pkg::REG_OFFSET: prdata = {24'd0, offset_q};
			rtqt_pkg::REG_THRESH: prdata = {25'd0, thresh_q};
			rtqt_pkg::REG_MINLEN:
				prdata = {{(rtqt_pkg::DATA_W-rtqt_pkg::LEN_W){1'b0}}, minlen_q};
			rtqt_pkg::REG_PAIRED: prdata = {31'd0, paired_q};
			default: prdata = '0;
		endcase
	end

	// input register
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			qual_s1 <= quality_byte;
			mate_s1 <= mate;
			end_s1  <= read_end;
		end
	end

	// per-byte trim and end-of-read decision
	always_comb begin
		pos_inc     = (pos_q < rtqt_pkg::LEN_CAP) ? pos_q + 1'b1 : pos_q;
		limit       = {1'b0, offset_q} + {2'b00, thresh_q};
		good        = {1'b0, qual_s1} > limit;
		good_len_nx = good ? pos_inc : good_len_q;
		first_end   = end_s1 && paired_q && !mate_s1;
		has_res     = end_s1 && !first_end;
		advance     = valid_s1 && (!out_valid || !out_stall || !has_res);

		len1 = paired_q ? held_len_q : good_len_nx;
		len2 = paired_q ? good_len_nx : '0;
		pass1 = len1 >= minlen_q;
		pass2 = len2 >= minlen_q;
		kept_add = 2'd0;
		disc_add = 2'd0;
		orph_add = 2'd0;
		if (paired_q) begin
			if (pass1 && pass2) begin
				fate1    = rtqt_pkg::FATE_PAIR;
				fate2    = rtqt_pkg::FATE_PAIR;
				kept_add = 2'd2;
			end else begin
				fate1    = pass1 ? rtqt_pkg::FATE_ALONE : rtqt_pkg::FATE_DROP;
				fate2    = pass2 ? rtqt_pkg::FATE_ALONE : rtqt_pkg::FATE_DROP;
				kept_add = {1'b0, pass1 || pass2};
				orph_add = {1'b0, pass1 || pass2};
				disc_add = 2'({1'b0, !pass1}) + 2'({1'b0, !pass2});
			end
		end else begin
			fate2 = rtqt_pkg::FATE_NONE;
			if (pass1) begin
				fate1    = rtqt_pkg::FATE_ALONE;
				kept_add = 2'd1;
				orph_add = 2'd1;
			end else begin
				fate1    = rtqt_pkg::FATE_DROP;
				disc_add = 2'd1;
			end
		end
		kept_nx = rtqt_pkg::sat_add(kept_q, kept_add);
		disc_nx = rtqt_pkg::sat_add(disc_q, disc_add);
		orph_nx = rtqt_pkg::sat_add(orph_q, orph_add);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			good_len_q <= '0;
			held_len_q <= '0;
			kept_q     <= '0;
			disc_q     <= '0;
			orph_q     <= '0;
		end else if (advance) begin
			if (!end_s1) begin
				pos_q      <= pos_inc;
				good_len_q <= good_len_nx;
			end else begin
				pos_q      <= '0;
				good_len_q <= '0;
				if (first_end) begin
					held_len_q <= good_len_nx;
				end else begin
					if (paired_q) begin
						held_len_q <= '0;
					end
					kept_q <= kept_nx;
					disc_q <= disc_nx;
					orph_q <= orph_nx;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && has_res) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			length_first    <= len1;
			length_second   <= len2;
			fate_first      <= fate1;
			fate_second     <= fate2;
			kept_total      <= kept_nx;
			discarded_total <= disc_nx;
			orphaned_total  <= orph_nx;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rtqt_checker.sv =====
// Port-level checks for the read tail quality trim block, bound to its top level.
`default_nettype none
module rtqt_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         out_valid,
	input wire                         out_stall,
	input wire [rtqt_pkg::LEN_W-1:0]   length_first,
	input wire [rtqt_pkg::LEN_W-1:0]   length_second,
	input wire [1:0]                   fate_first,
	input wire [1:0]                   fate_second,
	input wire [rtqt_pkg::CNT_W-1:0]   kept_total,
	input wire [rtqt_pkg::CNT_W-1:0]   discarded_total,
	input wire [rtqt_pkg::CNT_W-1:0]   orphaned_total
);

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(length_first)
			&& $stable(kept_total))
		else $error("stalled result changed");

	// totals never go down from one result item to the next
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall ##1 out_valid |->
			kept_total >= $past(kept_total)
			&& discarded_total >= $past(discarded_total)
			&& orphaned_total >= $past(orphaned_total))
		else $error("running total went down");

	// single mode result has no second mate
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fate_second == rtqt_pkg::FATE_NONE |->
			length_second == '0 && fate_first != rtqt_pkg::FATE_PAIR)
		else $error("single read result malformed");

	// pair fate is given to both mates or neither
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fate_first == rtqt_pkg::FATE_PAIR
			|| fate_second == rtqt_pkg::FATE_PAIR) |->
			fate_first == rtqt_pkg::FATE_PAIR && fate_second == rtqt_pkg::FATE_PAIR)
		else $error("pair fate on one mate only");

endmodule

bind read_tail_quality_trim_core rtqt_checker u_rtqt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.length_first    (length_first),
	.length_second   (length_second),
	.fate_first      (fate_first),
	.fate_second     (fate_second),
	.kept_total      (kept_total),
	.discarded_total (discarded_total),
	.orphaned_total  (orphaned_total)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for read_tail_quality_trim_core: directed table, then predictor-checked random reads.
`timescale 1ns / 100ps
module testbench;

	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_BYTES = 1750;

	typedef struct packed {
		logic [rtqt_pkg::LEN_W-1:0] len_first;
		logic [rtqt_pkg::LEN_W-1:0] len_second;
		logic [1:0]                 fate_first;
		logic [1:0]                 fate_second;
		logic [rtqt_pkg::CNT_W-1:0] kept;
		logic [rtqt_pkg::CNT_W-1:0] discarded;
		logic [rtqt_pkg::CNT_W-1:0] orphaned;
	} trim_result_t;

	typedef struct packed {
		logic         is_cfg;
		logic [1:0]   reg_idx;
		logic [31:0]  value;
		logic [7:0]   q;
		logic         m;
		logic         e;
		logic         typed;
		trim_result_t want;
	} plan_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [rtqt_pkg::ADDR_W-1:0]   paddr;
	logic [rtqt_pkg::DATA_W-1:0]   pwdata;
	logic [rtqt_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_stall;
	logic [7:0]                    quality_byte;
	logic                          mate;
	logic                          read_end;
	logic                          out_valid;
	logic                          out_stall;
	logic [rtqt_pkg::LEN_W-1:0]    length_first;
	logic [rtqt_pkg::LEN_W-1:0]    length_second;
	logic [1:0]                    fate_first;
	logic [1:0]                    fate_second;
	logic [rtqt_pkg::CNT_W-1:0]    kept_total;
	logic [rtqt_pkg::CNT_W-1:0]    discarded_total;
	logic [rtqt_pkg::CNT_W-1:0]    orphaned_total;

	// predictor copy of registers and state
	logic [7:0]                 cfg_offset = rtqt_pkg::OFFSET_RST;
	logic [6:0]                 cfg_thresh = rtqt_pkg::THRESH_RST;
	logic [rtqt_pkg::LEN_W-1:0] cfg_minlen = rtqt_pkg::MINLEN_RST;
	logic                       cfg_paired = 1'b0;
	logic [rtqt_pkg::LEN_W-1:0] pos = '0;
	logic [rtqt_pkg::LEN_W-1:0] good_len = '0;
	logic [rtqt_pkg::LEN_W-1:0] held_len = '0;
	logic [rtqt_pkg::CNT_W-1:0] kept_cnt = '0;
	logic [rtqt_pkg::CNT_W-1:0] disc_cnt = '0;
	logic [rtqt_pkg::CNT_W-1:0] orph_cnt = '0;

	trim_result_t trim_results_due[$];
	plan_row_t    plan[$];
	int           errors = 0;
	int           bytes_sent = 0;
	int unsigned  in_gap_max = 9;
	int unsigned  out_gap_max = 9;

	read_tail_quality_trim_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .quality_byte(quality_byte),
		.mate(mate), .read_end(read_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.length_first(length_first), .length_second(length_second),
		.fate_first(fate_first), .fate_second(fate_second),
		.kept_total(kept_total), .discarded_total(discarded_total),
		.orphaned_total(orphaned_total)
	);

	always #10 clk = ~clk;

	function automatic logic [rtqt_pkg::CNT_W-1:0] bump(input logic [rtqt_pkg::CNT_W-1:0] c,
		input int unsigned n);
		return (c > {rtqt_pkg::CNT_W{1'b1}} - n) ? {rtqt_pkg::CNT_W{1'b1}} : c + n;
	endfunction

	task automatic trim_predict(input logic [7:0] q, input logic m, input logic e,
		output logic emit, output trim_result_t r);
		logic p1, p2;
		emit = 1'b0;
		r = '0;
		if (pos < rtqt_pkg::LEN_CAP) pos = pos + 1'b1;
		if ({1'b0, q} > {1'b0, cfg_offset} + {2'b0, cfg_thresh}) good_len = pos;
		if (!e) return;
		if (cfg_paired && !m) begin
			held_len = good_len;
			pos = '0;
			good_len = '0;
			return;
		end
		emit = 1'b1;
		if (cfg_paired) begin
			r.len_first = held_len;
			r.len_second = good_len;
			p1 = held_len >= cfg_minlen;
			p2 = good_len >= cfg_minlen;
			if (p1 && p2) begin
				r.fate_first = rtqt_pkg::FATE_PAIR;
				r.fate_second = rtqt_pkg::FATE_PAIR;
				kept_cnt = bump(kept_cnt, 2);
			end else begin
				r.fate_first = p1 ? rtqt_pkg::FATE_ALONE : rtqt_pkg::FATE_DROP;
				r.fate_second = p2 ? rtqt_pkg::FATE_ALONE : rtqt_pkg::FATE_DROP;
				if (p1 || p2) begin
					kept_cnt = bump(kept_cnt, 1);
					orph_cnt = bump(orph_cnt, 1);
				end
				if (!p1) disc_cnt = bump(disc_cnt, 1);
				if (!p2) disc_cnt = bump(disc_cnt, 1);
			end
			held_len = '0;
		end else begin
			r.len_first = good_len;
			r.fate_second = rtqt_pkg::FATE_NONE;
			if (good_len >= cfg_minlen) begin
				r.fate_first = rtqt_pkg::FATE_ALONE;
				kept_cnt = bump(kept_cnt, 1);
				orph_cnt = bump(orph_cnt, 1);
			end else begin
				r.fate_first = rtqt_pkg::FATE_DROP;
				disc_cnt = bump(disc_cnt, 1);
			end
		end
		pos = '0;
		good_len = '0;
		r.kept = kept_cnt;
		r.discarded = disc_cnt;
		r.orphaned = orph_cnt;
	endtask

	task automatic send_item(input logic [7:0] q, input logic m, input logic e,
		input logic typed, input trim_result_t want);
		int unsigned gap;
		logic emit;
		trim_result_t r;
		@(negedge clk);
		gap = $urandom_range(0, in_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		quality_byte <= q;
		mate <= m;
		read_end <= e;
		do @(posedge clk); while (in_stall);
		trim_predict(q, m, e, emit, r);
		if (typed) trim_results_due.push_back(want);
		else if (emit) trim_results_due.push_back(r);
		bytes_sent++;
	endtask

	// idle the input, let every due result out, then allow for the pipeline
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (trim_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= rtqt_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			rtqt_pkg::REG_OFFSET: cfg_offset = val[7:0];
			rtqt_pkg::REG_THRESH: cfg_thresh = val[6:0];
			rtqt_pkg::REG_MINLEN: cfg_minlen = val[rtqt_pkg::LEN_W-1:0];
			rtqt_pkg::REG_PAIRED: cfg_paired = val[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_read(input logic m);
		int len, good_pct, limit;
		logic [7:0] q;
		trim_result_t none;
		none = '0;
		len = ($urandom_range(0, 39) == 0) ? $urandom_range(1000, 1100) : $urandom_range(1, 48);
		good_pct = $urandom_range(0, 100);
		limit = cfg_offset + cfg_thresh;
		for (int i = 1; i <= len; i++) begin
			if ($urandom_range(0, 7) == 0)
				q = 8'($urandom_range(0, 255));
			else if ($urandom_range(0, 99) < good_pct && limit < 255)
				q = 8'($urandom_range(limit + 1, 255));
			else
				q = 8'($urandom_range(0, (limit > 255) ? 255 : limit));
			send_item(q, (i == len) ? m : 1'($urandom_range(0, 1)), i == len, 1'b0, none);
		end
	endtask

	function automatic plan_row_t item_row(input logic [7:0] q, input logic m, input logic e);
		plan_row_t row;
		row = '0;
		row.q = q;
		row.m = m;
		row.e = e;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.value = val;
		return row;
	endfunction

	function automatic plan_row_t check_row(input logic [7:0] q, input logic m,
		input logic [rtqt_pkg::LEN_W-1:0] l1, input logic [rtqt_pkg::LEN_W-1:0] l2,
		input logic [1:0] f1, input logic [1:0] f2,
		input logic [rtqt_pkg::CNT_W-1:0] k, input logic [rtqt_pkg::CNT_W-1:0] d,
		input logic [rtqt_pkg::CNT_W-1:0] o);
		plan_row_t row;
		row = item_row(q, m, 1'b1);
		row.typed = 1'b1;
		row.want = '{l1, l2, f1, f2, k, d, o};
		return row;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		trim_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (trim_results_due.size() == 0) begin
				$error("result item with none expected");
				errors++;
			end else begin
				w = trim_results_due.pop_front();
				check_field("length_first", w.len_first, length_first);
				check_field("length_second", w.len_second, length_second);
				check_field("fate_first", w.fate_first, fate_first);
				check_field("fate_second", w.fate_second, fate_second);
				check_field("kept_total", w.kept, kept_total);
				check_field("discarded_total", w.discarded, discarded_total);
				check_field("orphaned_total", w.orphaned, orphaned_total);
			end
		end
	end

	// result side back-pressure
	initial begin
		int unsigned n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = $urandom_range(0, out_gap_max);
			out_stall <= (n != 0);
			if (n != 0) begin
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		#8_000_000;
		$display("read_tail_quality_trim_core verification failed");
		$finish;
	end

	initial begin
		int unsigned n_reads;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		quality_byte = '0;
		mate = 1'b0;
		read_end = 1'b0;

		// reset defaults, extremes of the byte, mate ignored in single mode
		plan.push_back(check_row(8'd255, 1'b0, 1, 0, rtqt_pkg::FATE_DROP,
			rtqt_pkg::FATE_NONE, 0, 1, 0));
		plan.push_back(check_row(8'd0, 1'b1, 0, 0, rtqt_pkg::FATE_DROP,
			rtqt_pkg::FATE_NONE, 0, 2, 0));
		// zero minimum keeps an empty read
		plan.push_back(cfg_row(rtqt_pkg::REG_MINLEN, 0));
		plan.push_back(check_row(8'd35, 1'b0, 0, 0, rtqt_pkg::FATE_ALONE,
			rtqt_pkg::FATE_NONE, 1, 2, 1));
		// offset plus threshold beyond a byte
		plan.push_back(cfg_row(rtqt_pkg::REG_OFFSET, 255));
		plan.push_back(cfg_row(rtqt_pkg::REG_THRESH, 127));
		plan.push_back(item_row(8'd255, 1'b0, 1'b0));
		plan.push_back(check_row(8'd255, 1'b0, 0, 0, rtqt_pkg::FATE_ALONE,
			rtqt_pkg::FATE_NONE, 2, 2, 2));
		// paired mode
		plan.push_back(cfg_row(rtqt_pkg::REG_OFFSET, 0));
		plan.push_back(cfg_row(rtqt_pkg::REG_THRESH, 0));
		plan.push_back(cfg_row(rtqt_pkg::REG_MINLEN, 2));
		plan.push_back(cfg_row(rtqt_pkg::REG_PAIRED, 1));
		plan.push_back(item_row(8'd1, 1'b0, 1'b0));
		plan.push_back(item_row(8'd1, 1'b0, 1'b1));
		plan.push_back(item_row(8'd0, 1'b1, 1'b0));
		plan.push_back(check_row(8'd5, 1'b1, 2, 2, rtqt_pkg::FATE_PAIR,
			rtqt_pkg::FATE_PAIR, 4, 2, 2));
		// second mate with no first
		plan.push_back(check_row(8'd7, 1'b1, 0, 1, rtqt_pkg::FATE_DROP,
			rtqt_pkg::FATE_DROP, 4, 4, 2));
		// two first mates, mate toggling mid read
		plan.push_back(item_row(8'd9, 1'b0, 1'b1));
		plan.push_back(item_row(8'd9, 1'b1, 1'b0));
		plan.push_back(item_row(8'd9, 1'b1, 1'b0));
		plan.push_back(item_row(8'd9, 1'b0, 1'b1));
		plan.push_back(check_row(8'd0, 1'b1, 3, 0, rtqt_pkg::FATE_ALONE,
			rtqt_pkg::FATE_DROP, 5, 5, 3));
		// mode change between mates; held length survives single mode
		plan.push_back(item_row(8'd9, 1'b0, 1'b1));
		plan.push_back(cfg_row(rtqt_pkg::REG_PAIRED, 0));
		plan.push_back(check_row(8'd9, 1'b1, 1, 0, rtqt_pkg::FATE_DROP,
			rtqt_pkg::FATE_NONE, 5, 6, 3));
		plan.push_back(cfg_row(rtqt_pkg::REG_PAIRED, 1));
		plan.push_back(check_row(8'd0, 1'b1, 1, 0, rtqt_pkg::FATE_DROP,
			rtqt_pkg::FATE_DROP, 5, 8, 3));
		plan.push_back(cfg_row(rtqt_pkg::REG_MINLEN, 1024));
		plan.push_back(item_row(8'd200, 1'b0, 1'b1));
		plan.push_back(item_row(8'd200, 1'b1, 1'b1));
		plan.push_back(cfg_row(rtqt_pkg::REG_MINLEN, 2047));
		plan.push_back(item_row(8'd255, 1'b1, 1'b1));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].value);
			end else begin
				send_item(plan[i].q, plan[i].m, plan[i].e, plan[i].typed, plan[i].want);
			end
		end

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			drain();
			case ($urandom_range(0, 3))
				0: write_reg(rtqt_pkg::REG_OFFSET, 33);
				1: write_reg(rtqt_pkg::REG_OFFSET, 255);
				2: write_reg(rtqt_pkg::REG_OFFSET, $urandom_range(0, 255));
				default: write_reg(rtqt_pkg::REG_OFFSET, $urandom_range(33, 80));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(rtqt_pkg::REG_THRESH, 0);
				1: write_reg(rtqt_pkg::REG_THRESH, 127);
				default: write_reg(rtqt_pkg::REG_THRESH, $urandom_range(0, 20));
			endcase
			case ($urandom_range(0, 7))
				0: write_reg(rtqt_pkg::REG_MINLEN, 0);
				1: write_reg(rtqt_pkg::REG_MINLEN, 1024);
				2: write_reg(rtqt_pkg::REG_MINLEN, 2047);
				default: write_reg(rtqt_pkg::REG_MINLEN, $urandom_range(1, 48));
			endcase
			write_reg(rtqt_pkg::REG_PAIRED, $urandom_range(0, 1));
			in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
			out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
			n_reads = $urandom_range(8, 24);
			for (int k = 0; k < n_reads && bytes_sent < RANDOM_BYTES; k++) begin
				if (cfg_paired) begin
					case ($urandom_range(0, 9))
						0: send_read(1'b1);
						1: begin
							send_read(1'b0);
							send_read(1'b0);
							send_read(1'b1);
						end
						default: begin
							send_read(1'b0);
							send_read(1'b1);
						end
					endcase
				end else begin
					send_read(1'($urandom_range(0, 1)));
				end
			end
		end

		drain();
		if (errors == 0)
			$display("read_tail_quality_trim_core verification clean");
		else
			$display("read_tail_quality_trim_core verification failed");
		$finish;
	end

endmodule
